>>> src/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DW        = 16;                // operand and result part width
   localparam int QW        = DW + 1;            // quotient bits kept (one spare for clip)
   localparam int NW        = 33 + FRAC_BITS;    // |numerator| after the fraction shift
   localparam int DENW      = 32;                // br^2 + bi^2
   localparam int SQW       = 2 * QW;            // radicand padded to whole digit pairs
   localparam int SRW       = QW + 2;            // root remainder
   localparam int WIDE      = 48;

   typedef logic [2:0] op_type;
   localparam op_type OP_ADD = 3'd0;
   localparam op_type OP_SUB = 3'd1;
   localparam op_type OP_MUL = 3'd2;
   localparam op_type OP_DIV = 3'd3;
   localparam op_type OP_MAG = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_SAT  = 2'd1;
   localparam status_type ST_DIVZ = 2'd2;

   localparam logic signed [DW-1:0] MAX_POS = 16'sh7FFF;
   localparam logic signed [DW-1:0] MAX_NEG = 16'sh8000;

   // One item in flight through the divide / root stages.
   typedef struct packed {
      op_type                 op;
      logic signed [DW-1:0]   dir_re;
      logic signed [DW-1:0]   dir_im;
      logic                   dir_sat;
      logic                   dz;
      logic                   neg_re;
      logic                   neg_im;
      logic                   ovf_re;
      logic                   ovf_im;
      logic [DENW-1:0]        den;
      logic [DENW-1:0]        rem_re;
      logic [DENW-1:0]        rem_im;
      logic [QW-1:0]          low_re;
      logic [QW-1:0]          low_im;
      logic [QW-1:0]          q_re;
      logic [QW-1:0]          q_im;
      logic [SQW-1:0]         sq_val;
      logic [SRW-1:0]         sq_rem;
      logic [QW-1:0]          sq_root;
   } lane_type;

   function automatic logic signed [DW-1:0] clip(input logic signed [WIDE-1:0] v);
      if (v > WIDE'(MAX_POS)) begin
         return MAX_POS;
      end else if (v < WIDE'(MAX_NEG)) begin
         return MAX_NEG;
      end
      return v[DW-1:0];
   endfunction

   function automatic logic clipped(input logic signed [WIDE-1:0] v);
      return (v > WIDE'(MAX_POS)) || (v < WIDE'(MAX_NEG));
   endfunction

endpackage

>>> src/cau_if.sv
// Valid/ready channel interfaces for operands and results.
// Depends on cau_pkg.
interface cau_req_if;
   import cau_pkg::*;
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic signed [DW-1:0] a_real;
   logic signed [DW-1:0] a_imag;
   logic signed [DW-1:0] b_real;
   logic signed [DW-1:0] b_imag;
   modport source (output valid, op, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, op, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if;
   import cau_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] res_real;
   logic signed [DW-1:0] res_imag;
   status_type           status;
   modport source (output valid, res_real, res_imag, status, input ready);
   modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

>>> src/cau_front.sv
// Front three stages: products, combine/add/sub/mul results, divide and root setup.
// Depends on cau_pkg and cau_if.
module cau_front
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   cau_req_if.sink  req_chan,
   output lane_type out_lane,
   output logic     out_valid,
   input  logic     out_ready
);

   // stage 1: products
   logic                 v1_ff;
   op_type               op1_ff;
   logic signed [DW-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [31:0]   p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [31:0]   p_aa_ff, p_bb_ff, p_br_ff, p_bi_ff;
   // stage 2: combined terms
   logic                 v2_ff;
   op_type               op2_ff;
   logic signed [DW-1:0] dre2_ff, dim2_ff;
   logic                 dsat2_ff, dz2_ff;
   logic signed [32:0]   nre2_ff, nim2_ff;
   logic [DENW-1:0]      den2_ff;
   logic [31:0]          mag2_ff;
   // stage 3
   logic                 v3_ff;
   lane_type             lane3_ff;

   logic rdy1, rdy2, rdy3;
   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_chan.valid;
      end
      if (req_chan.valid && rdy1) begin
         op1_ff  <= req_chan.op;
         ar_ff   <= req_chan.a_real;
         ai_ff   <= req_chan.a_imag;
         br_ff   <= req_chan.b_real;
         bi_ff   <= req_chan.b_imag;
         p_rr_ff <= req_chan.a_real * req_chan.b_real;
         p_ii_ff <= req_chan.a_imag * req_chan.b_imag;
         p_ir_ff <= req_chan.a_imag * req_chan.b_real;
         p_ri_ff <= req_chan.a_real * req_chan.b_imag;
         p_aa_ff <= req_chan.a_real * req_chan.a_real;
         p_bb_ff <= req_chan.a_imag * req_chan.a_imag;
         p_br_ff <= req_chan.b_real * req_chan.b_real;
         p_bi_ff <= req_chan.b_imag * req_chan.b_imag;
      end
   end

   // stage 2 logic
   logic signed [WIDE-1:0] s_re, s_im;
   logic signed [32:0]     m_re, m_im;
   logic signed [DW-1:0]   dre2_in, dim2_in;
   logic                   dsat2_in;
   logic [DENW-1:0]        den2_in;

   always_comb begin
      m_re = 33'(p_rr_ff) - 33'(p_ii_ff);
      m_im = 33'(p_ir_ff) + 33'(p_ri_ff);
      s_re = '0;
      s_im = '0;
      case (op1_ff)
         OP_ADD: begin
            s_re = WIDE'(ar_ff) + WIDE'(br_ff);
            s_im = WIDE'(ai_ff) + WIDE'(bi_ff);
         end
         OP_SUB: begin
            s_re = WIDE'(ar_ff) - WIDE'(br_ff);
            s_im = WIDE'(ai_ff) - WIDE'(bi_ff);
         end
         OP_MUL: begin
            s_re = WIDE'(m_re >>> FRAC_BITS);
            s_im = WIDE'(m_im >>> FRAC_BITS);
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      dre2_in  = clip(s_re);
      dim2_in  = clip(s_im);
      dsat2_in = clipped(s_re) || clipped(s_im);
      den2_in  = DENW'(p_br_ff) + DENW'(p_bi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (v1_ff && rdy2) begin
         op2_ff   <= op1_ff;
         dre2_ff  <= dre2_in;
         dim2_ff  <= dim2_in;
         dsat2_ff <= dsat2_in;
         nre2_ff  <= 33'(p_rr_ff) + 33'(p_ii_ff);
         nim2_ff  <= 33'(p_ir_ff) - 33'(p_ri_ff);
         den2_ff  <= den2_in;
         dz2_ff   <= (den2_in == '0);
         mag2_ff  <= 32'(p_aa_ff) + 32'(p_bb_ff);
      end
   end

   // stage 3: magnitudes of the numerators and the overflow precheck
   logic [32:0]    abs_re, abs_im;
   logic [NW-1:0]  sh_re, sh_im;
   lane_type       lane3_in;

   always_comb begin
      abs_re = nre2_ff[32] ? 33'(-nre2_ff) : 33'(nre2_ff);
      abs_im = nim2_ff[32] ? 33'(-nim2_ff) : 33'(nim2_ff);
      sh_re  = NW'(abs_re) << FRAC_BITS;
      sh_im  = NW'(abs_im) << FRAC_BITS;
      lane3_in         = '0;
      lane3_in.op      = op2_ff;
      lane3_in.dir_re  = dre2_ff;
      lane3_in.dir_im  = dim2_ff;
      lane3_in.dir_sat = dsat2_ff;
      lane3_in.dz      = dz2_ff;
      lane3_in.neg_re  = nre2_ff[32];
      lane3_in.neg_im  = nim2_ff[32];
      // quotient cannot fit in QW bits when the high part already reaches the divisor
      lane3_in.ovf_re  = (sh_re >> QW) >= NW'(den2_ff);
      lane3_in.ovf_im  = (sh_im >> QW) >= NW'(den2_ff);
      lane3_in.den     = den2_ff;
      lane3_in.rem_re  = DENW'(sh_re >> QW);
      lane3_in.rem_im  = DENW'(sh_im >> QW);
      lane3_in.low_re  = sh_re[QW-1:0];
      lane3_in.low_im  = sh_im[QW-1:0];
      lane3_in.sq_val  = SQW'(mag2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (v2_ff && rdy3) begin
         lane3_ff <= lane3_in;
      end
   end

   assign out_lane  = lane3_ff;
   assign out_valid = v3_ff;

endmodule

>>> src/cau_step.sv
// One pipeline stage: one restoring-divide bit for each part, one square-root digit.
// Depends on cau_pkg.
module cau_step
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  lane_type in_lane,
   input  logic     in_valid,
   output logic     in_ready,
   output lane_type out_lane,
   output logic     out_valid,
   input  logic     out_ready
);

   logic     v_ff;
   lane_type lane_ff;
   lane_type lane_in;

   logic [DENW:0]  t_re, t_im;
   logic [SRW+1:0] s_rem, s_try;

   always_comb begin
      lane_in = in_lane;
      // divide, real part
      t_re = {in_lane.rem_re, in_lane.low_re[QW-1]};
      if (t_re >= (DENW+1)'(in_lane.den)) begin
         lane_in.rem_re = DENW'(t_re - (DENW+1)'(in_lane.den));
         lane_in.q_re   = {in_lane.q_re[QW-2:0], 1'b1};
      end else begin
         lane_in.rem_re = t_re[DENW-1:0];
         lane_in.q_re   = {in_lane.q_re[QW-2:0], 1'b0};
      end
      lane_in.low_re = in_lane.low_re << 1;
      // divide, imaginary part
      t_im = {in_lane.rem_im, in_lane.low_im[QW-1]};
      if (t_im >= (DENW+1)'(in_lane.den)) begin
         lane_in.rem_im = DENW'(t_im - (DENW+1)'(in_lane.den));
         lane_in.q_im   = {in_lane.q_im[QW-2:0], 1'b1};
      end else begin
         lane_in.rem_im = t_im[DENW-1:0];
         lane_in.q_im   = {in_lane.q_im[QW-2:0], 1'b0};
      end
      lane_in.low_im = in_lane.low_im << 1;
      // square root, next digit pair from the top
      s_rem = {in_lane.sq_rem, in_lane.sq_val[SQW-1:SQW-2]};
      s_try = (SRW+2)'({in_lane.sq_root, 2'b01});
      if (s_rem >= s_try) begin
         lane_in.sq_rem  = SRW'(s_rem - s_try);
         lane_in.sq_root = {in_lane.sq_root[QW-2:0], 1'b1};
      end else begin
         lane_in.sq_rem  = SRW'(s_rem);
         lane_in.sq_root = {in_lane.sq_root[QW-2:0], 1'b0};
      end
      lane_in.sq_val = in_lane.sq_val << 2;
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane  = lane_ff;
   assign out_valid = v_ff;

endmodule

>>> src/cau_back.sv
// Output stage: signs and clips the quotients and root, picks the result, holds the beat.
// Depends on cau_pkg and cau_if.
module cau_back
   import cau_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  lane_type  in_lane,
   input  logic      in_valid,
   output logic      in_ready,
   cau_rsp_if.source rsp_chan
);

   logic                 v_ff;
   logic signed [DW-1:0] re_ff, im_ff;
   status_type           st_ff;

   logic signed [DW-1:0] re_in, im_in, qre, qim;
   logic                 sat_re, sat_im, sat;
   status_type           st_in;

   always_comb begin
      if (in_lane.neg_re) begin
         sat_re = in_lane.ovf_re || (in_lane.q_re > QW'(32768));
         qre    = sat_re ? MAX_NEG : DW'(-in_lane.q_re);
      end else begin
         sat_re = in_lane.ovf_re || (in_lane.q_re > QW'(32767));
         qre    = sat_re ? MAX_POS : DW'(in_lane.q_re);
      end
      if (in_lane.neg_im) begin
         sat_im = in_lane.ovf_im || (in_lane.q_im > QW'(32768));
         qim    = sat_im ? MAX_NEG : DW'(-in_lane.q_im);
      end else begin
         sat_im = in_lane.ovf_im || (in_lane.q_im > QW'(32767));
         qim    = sat_im ? MAX_POS : DW'(in_lane.q_im);
      end
      re_in = in_lane.dir_re;
      im_in = in_lane.dir_im;
      sat   = in_lane.dir_sat;
      st_in = ST_OK;
      case (in_lane.op)
         OP_DIV: begin
            re_in = in_lane.dz ? '0 : qre;
            im_in = in_lane.dz ? '0 : qim;
            sat   = !in_lane.dz && (sat_re || sat_im);
         end
         OP_MAG: begin
            sat   = in_lane.sq_root > QW'(32767);
            re_in = sat ? MAX_POS : DW'(in_lane.sq_root);
            im_in = '0;
         end
         default: begin
         end
      endcase
      if (in_lane.op == OP_DIV && in_lane.dz) begin
         st_in = ST_DIVZ;
      end else if (sat) begin
         st_in = ST_SAT;
      end
   end

   assign in_ready = !v_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         re_ff <= re_in;
         im_ff <= im_in;
         st_ff <= st_in;
      end
   end

   assign rsp_chan.valid    = v_ff;
   assign rsp_chan.res_real = re_ff;
   assign rsp_chan.res_imag = im_ff;
   assign rsp_chan.status   = st_ff;

endmodule

>>> src/complex_arithmetic_unit.sv
// Complex ALU on signed Q8.8 operands: add, subtract, multiply, divide and magnitude of a.
// One operand beat is accepted every cycle while the output is not stalled, and each
// result leaves after its beat has passed three front stages (products, combine,
// divide setup), 17 shared divide/square-root digit stages and an output register. All
// ops take the same path, so results come back in order. Any stage holds under
// backpressure and the one ahead of it keeps filling. Depends on cau_pkg, cau_if,
// cau_front, cau_step and cau_back.
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);

   lane_type lane [0:QW];
   logic     vld  [0:QW];
   logic     rdy  [0:QW];

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_lane  (lane[0]),
      .out_valid (vld[0]),
      .out_ready (rdy[0])
   );

   for (genvar k = 0; k < QW; k++) begin : g_step
      cau_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_lane   (lane[k]),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .out_lane  (lane[k+1]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1])
      );
   end

   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_lane  (lane[QW]),
      .in_valid (vld[QW]),
      .in_ready (rdy[QW]),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> src/cau_checker.sv
// Port-level checks for complex_arithmetic_unit, attached by bind.
// Depends on cau_pkg.
module cau_checker
   import cau_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [DW-1:0] rsp_real,
   input logic signed [DW-1:0] rsp_imag,
   input status_type           rsp_status
);

   a_no_beat_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result beat right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_SAT || rsp_status == ST_DIVZ))
      else $error("unused status code");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIVZ |-> rsp_real == '0 && rsp_imag == '0)
      else $error("divide by zero beat with nonzero parts");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_real) && $stable(rsp_imag)
      && $stable(rsp_status)) else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_real   (rsp_chan.res_real),
   .rsp_imag   (rsp_chan.res_imag),
   .rsp_status (rsp_chan.status)
);
